// ----- rtl/pcf_pkg.sv -----
// Package for the patch convolution forward block: field widths, op and
// register codes, and the control word passed to the multiply-accumulate unit.
// No dependencies.
package pcf_pkg;

   localparam int MAX_FEATURES_DEF    = 1024;
   localparam int MAX_FILTERS_DEF     = 64;
   localparam int MAX_FILTER_TAPS_DEF = 256;

   localparam int OP_W       = 2;
   localparam int POS_W      = 10;
   localparam int FILT_W     = 6;
   localparam int SAMPLE_W   = 16;
   localparam int BIAS_W     = 32;
   localparam int ACT_W      = 32;

   localparam int PW_W       = 9;
   localparam int STEP_W     = 11;
   localparam int STRIDE_W   = 11;
   localparam int SC_W       = 9;
   localparam int FC_W       = 7;
   localparam int SHIFT_W    = 5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 11;

   // patch start plus splice offset plus tap stays below 2^21
   localparam int XI_W = 21;

   typedef enum logic [OP_W-1:0] {
      OP_WEIGHT  = 2'd0,
      OP_BIAS    = 2'd1,
      OP_FEATURE = 2'd2,
      OP_COMPUTE = 2'd3
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATCH_WIDTH   = 3'd0,
      CSR_PATCH_STEP    = 3'd1,
      CSR_SPLICE_STRIDE = 3'd2,
      CSR_SPLICE_COUNT  = 3'd3,
      CSR_FILTER_COUNT  = 3'd4,
      CSR_OUT_SHIFT     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic load_bias;
      logic tap_valid;
      logic feat_valid;
      logic finish;
   } mac_ctrl_type;

endpackage

// ----- rtl/patch_convolution_forward.sv -----
// Top level of the patch convolution forward block: configuration registers,
// sequencer and the three stores. Depends on pcf_pkg, pcf_ram, pcf_mac.
//
// Usage:
//   req_ channel (valid/ready) carries one word: op, position, filter_index,
//   sample, bias_value. Weight, bias and feature words are written to their
//   store at the accept edge and give no rsp_ word; the sequencer stays idle.
//   A compute word gives exactly one rsp_ word: activation, out_patch,
//   out_filter, saturated.
//   A compute word reads the weight and feature stores once per tap, one tap
//   per cycle, over N = min(splice_count * patch_width, MAX_FILTER_TAPS)
//   taps; a filter not in use skips the tap loop and answers from DONE.
//   One word is in work at a time; req_ready is high only between words.
//   The result sits in an output register, so the next word is accepted and
//   worked on while the receiver stalls; that word's result waits until the
//   output register is free.
//   csr_ port writes a register; write only while idle.
//   Reset (synchronous) sets the registers to defaults and empties the output
//   register. The stores are not cleared.
module patch_convolution_forward #(
   parameter int MAX_FEATURES    = pcf_pkg::MAX_FEATURES_DEF,
   parameter int MAX_FILTERS     = pcf_pkg::MAX_FILTERS_DEF,
   parameter int MAX_FILTER_TAPS = pcf_pkg::MAX_FILTER_TAPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pcf_pkg::OP_W-1:0]             req_op,
   input  logic [pcf_pkg::POS_W-1:0]            req_position,
   input  logic [pcf_pkg::FILT_W-1:0]           req_filter_index,
   input  logic signed [pcf_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic signed [pcf_pkg::BIAS_W-1:0]    req_bias_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pcf_pkg::ACT_W-1:0]     rsp_activation,
   output logic [pcf_pkg::POS_W-1:0]            rsp_out_patch,
   output logic [pcf_pkg::FILT_W-1:0]           rsp_out_filter,
   output logic                                 rsp_saturated,
   input  logic                                 csr_write,
   input  logic [pcf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pcf_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int FAW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int FIW    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
   localparam int TW     = $clog2(MAX_FILTER_TAPS);
   localparam int WDEPTH = MAX_FILTERS * MAX_FILTER_TAPS;
   localparam int WAW    = $clog2(WDEPTH);
   localparam int FMAX   = (MAX_FILTERS < 64) ? MAX_FILTERS : 64;
   localparam int XI_W   = pcf_pkg::XI_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_RUN,
      S_DRAIN_A,
      S_DRAIN_B,
      S_SHIFT,
      S_DONE
   } state_type;

   // configuration
   logic [pcf_pkg::PW_W-1:0]     pw_ff;
   logic [pcf_pkg::STEP_W-1:0]   step_ff;
   logic [pcf_pkg::STRIDE_W-1:0] stride_ff;
   logic [pcf_pkg::SC_W-1:0]     sc_ff;
   logic [pcf_pkg::FC_W-1:0]     fc_ff;
   logic [pcf_pkg::SHIFT_W-1:0]  shift_ff;

   logic [pcf_pkg::PW_W-1:0]     csr_v9;
   logic [pcf_pkg::STEP_W-1:0]   csr_v11;
   logic [pcf_pkg::FC_W-1:0]     csr_v7;

   // sequencer
   state_type                    state_ff;
   logic [pcf_pkg::POS_W-1:0]    pos_ff;
   logic [pcf_pkg::FILT_W-1:0]   f_ff;
   logic                         in_use_ff;
   logic [WAW-1:0]               wbase_ff;
   logic [XI_W-1:0]              xi_ff;
   logic [XI_W-1:0]              splice_base_ff;
   logic [pcf_pkg::PW_W-1:0]     d_ff;
   logic [pcf_pkg::SC_W-1:0]     s_ff;
   logic [TW-1:0]                tap_ff;
   logic                         tap_valid_ff;
   logic                         feat_valid_ff;
   logic                         load_bias_ff;

   logic                         rsp_valid_ff;
   logic signed [pcf_pkg::ACT_W-1:0] rsp_activation_ff;
   logic [pcf_pkg::POS_W-1:0]    rsp_out_patch_ff;
   logic [pcf_pkg::FILT_W-1:0]   rsp_out_filter_ff;
   logic                         rsp_saturated_ff;

   logic                         accept;
   logic                         rsp_load;
   logic                         end_splice;
   logic                         last_splice;
   logic                         last_tap;
   logic                         run_done;
   logic                         x_in_range;

   // store ports
   logic                         w_we;
   logic [WAW-1:0]               w_waddr;
   logic [WAW-1:0]               w_raddr;
   logic [pcf_pkg::SAMPLE_W-1:0] w_rdata;
   logic                         x_we;
   logic [FAW-1:0]               x_waddr;
   logic [FAW-1:0]               x_raddr;
   logic [pcf_pkg::SAMPLE_W-1:0] x_rdata;
   logic                         b_we;
   logic [FIW-1:0]               b_waddr;
   logic [pcf_pkg::BIAS_W-1:0]   b_rdata;

   pcf_pkg::mac_ctrl_type        mac_ctrl;
   logic signed [pcf_pkg::ACT_W-1:0] mac_act;
   logic                         mac_sat;

   // ---------------- configuration registers ----------------
   assign csr_v9  = csr_data[pcf_pkg::PW_W-1:0];
   assign csr_v11 = csr_data[pcf_pkg::STEP_W-1:0];
   assign csr_v7  = csr_data[pcf_pkg::FC_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff     <= pcf_pkg::PW_W'(1);
         step_ff   <= pcf_pkg::STEP_W'(1);
         stride_ff <= pcf_pkg::STRIDE_W'(1);
         sc_ff     <= pcf_pkg::SC_W'(1);
         fc_ff     <= pcf_pkg::FC_W'(1);
         shift_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            pcf_pkg::CSR_PATCH_WIDTH: begin
               pw_ff <= (csr_v9 == '0) ? pcf_pkg::PW_W'(1) :
                        (csr_v9 > pcf_pkg::PW_W'(256)) ? pcf_pkg::PW_W'(256) : csr_v9;
            end
            pcf_pkg::CSR_PATCH_STEP: begin
               step_ff <= (csr_v11 == '0) ? pcf_pkg::STEP_W'(1) :
                          (csr_v11 > pcf_pkg::STEP_W'(1024)) ? pcf_pkg::STEP_W'(1024) :
                          csr_v11;
            end
            pcf_pkg::CSR_SPLICE_STRIDE: begin
               stride_ff <= (csr_v11 == '0) ? pcf_pkg::STRIDE_W'(1) :
                            (csr_v11 > pcf_pkg::STRIDE_W'(1024)) ?
                            pcf_pkg::STRIDE_W'(1024) : csr_v11;
            end
            pcf_pkg::CSR_SPLICE_COUNT: begin
               sc_ff <= (csr_v9 == '0) ? pcf_pkg::SC_W'(1) :
                        (csr_v9 > pcf_pkg::SC_W'(256)) ? pcf_pkg::SC_W'(256) : csr_v9;
            end
            pcf_pkg::CSR_FILTER_COUNT: begin
               fc_ff <= (csr_v7 == '0) ? pcf_pkg::FC_W'(1) :
                        (int'(csr_v7) > FMAX) ? pcf_pkg::FC_W'(FMAX) : csr_v7;
            end
            pcf_pkg::CSR_OUT_SHIFT: begin
               shift_ff <= csr_data[pcf_pkg::SHIFT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- store ports ----------------
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign w_we    = accept && (req_op == pcf_pkg::OP_WEIGHT) &&
                    (int'(req_position) < MAX_FILTER_TAPS) &&
                    (int'(req_filter_index) < MAX_FILTERS);
   assign w_waddr = WAW'(req_filter_index) * WAW'(MAX_FILTER_TAPS) + WAW'(req_position);
   assign w_raddr = wbase_ff + WAW'(tap_ff);

   assign x_we       = accept && (req_op == pcf_pkg::OP_FEATURE) &&
                       (int'(req_position) < MAX_FEATURES);
   assign x_waddr    = FAW'(req_position);
   assign x_in_range = (xi_ff < XI_W'(MAX_FEATURES));
   assign x_raddr    = x_in_range ? xi_ff[FAW-1:0] : '0;

   assign b_we    = accept && (req_op == pcf_pkg::OP_BIAS) &&
                    (int'(req_filter_index) < MAX_FILTERS);
   assign b_waddr = FIW'(req_filter_index);

   pcf_ram #(
      .WIDTH (pcf_pkg::SAMPLE_W),
      .DEPTH (WDEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_we),
      .wr_addr (w_waddr),
      .wr_data (req_sample),
      .rd_en   (state_ff == S_RUN),
      .rd_addr (w_raddr),
      .rd_data (w_rdata)
   );

   pcf_ram #(
      .WIDTH (pcf_pkg::SAMPLE_W),
      .DEPTH (MAX_FEATURES)
   ) u_feature_ram (
      .clock   (clock),
      .wr_en   (x_we),
      .wr_addr (x_waddr),
      .wr_data (req_sample),
      .rd_en   (state_ff == S_RUN),
      .rd_addr (x_raddr),
      .rd_data (x_rdata)
   );

   pcf_ram #(
      .WIDTH (pcf_pkg::BIAS_W),
      .DEPTH (MAX_FILTERS)
   ) u_bias_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (req_bias_value),
      .rd_en   (state_ff == S_SETUP),
      .rd_addr (FIW'(f_ff)),
      .rd_data (b_rdata)
   );

   // ---------------- multiply-accumulate ----------------
   assign mac_ctrl.load_bias  = load_bias_ff;
   assign mac_ctrl.tap_valid  = tap_valid_ff;
   assign mac_ctrl.feat_valid = feat_valid_ff;
   assign mac_ctrl.finish     = (state_ff == S_SHIFT);

   pcf_mac #(
      .MAX_FILTER_TAPS (MAX_FILTER_TAPS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .shift      (shift_ff),
      .bias_word  (b_rdata),
      .weight     (w_rdata),
      .feature    (x_rdata),
      .activation (mac_act),
      .saturated  (mac_sat)
   );

   // ---------------- sequencer ----------------
   assign end_splice  = (d_ff == pcf_pkg::PW_W'(pw_ff - pcf_pkg::PW_W'(1)));
   assign last_splice = (s_ff == pcf_pkg::SC_W'(sc_ff - pcf_pkg::SC_W'(1)));
   assign last_tap    = (tap_ff == TW'(MAX_FILTER_TAPS - 1));
   assign run_done    = last_tap || (end_splice && last_splice);
   assign rsp_load    = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         tap_valid_ff  <= 1'b0;
         feat_valid_ff <= 1'b0;
         load_bias_ff  <= 1'b0;
      end else begin
         tap_valid_ff  <= (state_ff == S_RUN);
         feat_valid_ff <= (state_ff == S_RUN) && x_in_range;
         load_bias_ff  <= (state_ff == S_SETUP);
         rsp_valid_ff  <= rsp_load || (rsp_valid_ff && !rsp_ready);
         unique case (state_ff)
            S_IDLE: begin
               if (accept && (req_op == pcf_pkg::OP_COMPUTE)) begin
                  pos_ff    <= req_position;
                  f_ff      <= req_filter_index;
                  in_use_ff <= ({1'b0, req_filter_index} < fc_ff);
                  state_ff  <= ({1'b0, req_filter_index} < fc_ff) ? S_SETUP : S_DONE;
               end
            end
            S_SETUP: begin
               wbase_ff       <= WAW'(f_ff) * WAW'(MAX_FILTER_TAPS);
               xi_ff          <= XI_W'(pos_ff) * XI_W'(step_ff);
               splice_base_ff <= XI_W'(pos_ff) * XI_W'(step_ff);
               d_ff           <= '0;
               s_ff           <= '0;
               tap_ff         <= '0;
               state_ff       <= S_RUN;
            end
            S_RUN: begin
               tap_ff <= tap_ff + TW'(1);
               if (end_splice) begin
                  d_ff           <= '0;
                  s_ff           <= s_ff + pcf_pkg::SC_W'(1);
                  splice_base_ff <= splice_base_ff + XI_W'(stride_ff);
                  xi_ff          <= splice_base_ff + XI_W'(stride_ff);
               end else begin
                  d_ff  <= d_ff + pcf_pkg::PW_W'(1);
                  xi_ff <= xi_ff + XI_W'(1);
               end
               if (run_done) begin
                  state_ff <= S_DRAIN_A;
               end
            end
            S_DRAIN_A: begin
               state_ff <= S_DRAIN_B;
            end
            S_DRAIN_B: begin
               state_ff <= S_SHIFT;
            end
            S_SHIFT: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_activation_ff <= in_use_ff ? mac_act : '0;
                  rsp_saturated_ff  <= in_use_ff && mac_sat;
                  rsp_out_patch_ff  <= pos_ff;
                  rsp_out_filter_ff <= f_ff;
                  state_ff          <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_activation = rsp_activation_ff;
   assign rsp_out_patch  = rsp_out_patch_ff;
   assign rsp_out_filter = rsp_out_filter_ff;
   assign rsp_saturated  = rsp_saturated_ff;

`ifndef SYNTHESIS
   a_compute_starts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == pcf_pkg::OP_COMPUTE)) |=> (state_ff != S_IDLE))
      else $error("compute word accepted but sequencer stayed idle");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && rsp_valid_ff && !rsp_ready) |=> (state_ff == S_DONE))
      else $error("result left DONE while output register was occupied");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("rsp_valid rose outside DONE");

   a_run_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |=> ((state_ff == S_RUN) || (state_ff == S_DRAIN_A)))
      else $error("tap loop left to an unexpected state");
`endif

endmodule

// ----- rtl/pcf_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one registered read port.
// No dependencies.
module pcf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pcf_mac.sv -----
// Multiply-accumulate datapath: registered product, exact accumulator,
// floor shift and 32-bit saturation. Depends on pcf_pkg.
module pcf_mac #(
   parameter int MAX_FILTER_TAPS = pcf_pkg::MAX_FILTER_TAPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pcf_pkg::mac_ctrl_type             ctrl,
   input  logic [pcf_pkg::SHIFT_W-1:0]       shift,
   input  logic [pcf_pkg::BIAS_W-1:0]        bias_word,
   input  logic [pcf_pkg::SAMPLE_W-1:0]      weight,
   input  logic [pcf_pkg::SAMPLE_W-1:0]      feature,
   output logic signed [pcf_pkg::ACT_W-1:0]  activation,
   output logic                              saturated
);

   localparam int ACC_W  = pcf_pkg::ACT_W + $clog2(MAX_FILTER_TAPS) + 2;
   localparam int PROD_W = 2 * pcf_pkg::SAMPLE_W;

   logic signed [pcf_pkg::SAMPLE_W-1:0] x_sel;
   logic signed [PROD_W-1:0]            prod_ff;
   logic                                pv_ff;
   logic signed [ACC_W-1:0]             acc_ff;
   logic signed [ACC_W-1:0]             shifted;
   logic                                fits;
   logic signed [pcf_pkg::ACT_W-1:0]    act_ff;
   logic                                sat_ff;

   assign x_sel   = ctrl.feat_valid ? $signed(feature) : '0;
   assign shifted = acc_ff >>> shift;
   assign fits    = (&shifted[ACC_W-1:pcf_pkg::ACT_W-1]) ||
                    (~|shifted[ACC_W-1:pcf_pkg::ACT_W-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else begin
         pv_ff <= ctrl.tap_valid;
      end
      prod_ff <= PROD_W'($signed(weight) * x_sel);
      if (ctrl.load_bias) begin
         acc_ff <= ACC_W'($signed(bias_word));
      end else if (pv_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (ctrl.finish) begin
         if (fits) begin
            act_ff <= shifted[pcf_pkg::ACT_W-1:0];
         end else if (shifted[ACC_W-1]) begin
            act_ff <= {1'b1, {(pcf_pkg::ACT_W-1){1'b0}}};
         end else begin
            act_ff <= {1'b0, {(pcf_pkg::ACT_W-1){1'b1}}};
         end
         sat_ff <= !fits;
      end
   end

   assign activation = act_ff;
   assign saturated  = sat_ff;

endmodule

// ----- tb/patch_convolution_forward_tb.sv -----
// Self-checking testbench for patch_convolution_forward: drives weight, bias, feature
// and compute words and checks every response against a local predictor.
// Depends on pcf_pkg and the patch_convolution_forward RTL.
module patch_convolution_forward_tb;
   import pcf_pkg::*;

   localparam int FEAT_DEPTH   = MAX_FEATURES_DEF;
   localparam int FILTER_SLOTS = MAX_FILTERS_DEF;
   localparam int TAP_SLOTS    = MAX_FILTER_TAPS_DEF;
   localparam int TOTAL_WORDS  = 1900;
   localparam int CSR_SETTLE   = 4;
   localparam int END_SETTLE   = TAP_SLOTS + 40;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic signed [63:0] ACT_HI = 64'sh7FFF_FFFF;
   localparam logic signed [63:0] ACT_LO = -64'sh8000_0000;

   typedef struct {
      logic signed [ACT_W-1:0] activation;
      logic [POS_W-1:0]        patch;
      logic [FILT_W-1:0]       filter;
      logic                    saturated;
   } response_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_W-1:0] req_op = OP_WEIGHT;
   logic [POS_W-1:0] req_position = '0;
   logic [FILT_W-1:0] req_filter_index = '0;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic signed [BIAS_W-1:0] req_bias_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [ACT_W-1:0] rsp_activation;
   logic [POS_W-1:0] rsp_out_patch;
   logic [FILT_W-1:0] rsp_out_filter;
   logic rsp_saturated;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_PATCH_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   patch_convolution_forward u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_position(req_position), .req_filter_index(req_filter_index),
      .req_sample(req_sample), .req_bias_value(req_bias_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_activation(rsp_activation),
      .rsp_out_patch(rsp_out_patch), .rsp_out_filter(rsp_out_filter),
      .rsp_saturated(rsp_saturated),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // predictor state
   logic signed [SAMPLE_W-1:0] feat_mem [FEAT_DEPTH];
   bit feat_known [FEAT_DEPTH];
   logic signed [SAMPLE_W-1:0] coef_mem [FILTER_SLOTS][TAP_SLOTS];
   bit coef_known [FILTER_SLOTS][TAP_SLOTS];
   logic signed [BIAS_W-1:0] bias_mem [FILTER_SLOTS];
   bit bias_known [FILTER_SLOTS];
   int unsigned taps_per_splice = 1;
   int unsigned patch_hop = 1;
   int unsigned splice_gap = 1;
   int unsigned splices = 1;
   int unsigned filters_live = 1;
   int unsigned acc_shift = 0;

   response_type pending_responses[$];
   int unsigned mismatches = 0;
   int unsigned words_accepted = 0;
   int unsigned useful_words = 0;
   int unsigned responses_checked = 0;
   int unsigned sat_high = 0;
   int unsigned sat_low = 0;
   int unsigned settings_used = 0;
   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int rsp_hold_request = 0;
   int rsp_hold_left = 0;
   int rsp_stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d responses outstanding", pending_responses.size());
      $display("patch_convolution_forward_tb: FAIL");
      $finish;
   end

   function automatic int unsigned bound(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [SAMPLE_W-1:0] draw_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 16'h8000;
      if (r < 30) return 16'h7FFF;
      if (r < 35) return '0;
      return SAMPLE_W'($urandom());
   endfunction

   function automatic logic [BIAS_W-1:0] draw_bias();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 32'h7FFF_FFFF;
      if (r < 30) return 32'h8000_0000;
      if (r < 45) return $urandom_range(0, 65535) - 32768;
      return $urandom();
   endfunction

   function automatic int unsigned draw_setting(int unsigned typical_hi, int unsigned full_hi);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, typical_hi);
      if (r < 85) return $urandom_range(1, full_hi);
      return $urandom_range(0, 2 ** CSR_DATA_W - 1);
   endfunction

   function automatic int unsigned live_taps();
      return bound(splices * taps_per_splice, 1, TAP_SLOTS);
   endfunction

   // wide filters come from a small pool so the weight preload stays bounded
   function automatic logic [FILT_W-1:0] pick_filter();
      if (live_taps() <= 16) return FILT_W'($urandom_range(0, FILTER_SLOTS - 1));
      return FILT_W'(21 * $urandom_range(0, 3));
   endfunction

   function automatic void apply_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_PATCH_WIDTH:   taps_per_splice = bound(int'(data[PW_W-1:0]), 1, 256);
         CSR_PATCH_STEP:    patch_hop = bound(int'(data[STEP_W-1:0]), 1, 1024);
         CSR_SPLICE_STRIDE: splice_gap = bound(int'(data[STRIDE_W-1:0]), 1, 1024);
         CSR_SPLICE_COUNT:  splices = bound(int'(data[SC_W-1:0]), 1, 256);
         CSR_FILTER_COUNT:  filters_live = bound(int'(data[FC_W-1:0]), 1, FILTER_SLOTS);
         CSR_OUT_SHIFT:     acc_shift = int'(data[SHIFT_W-1:0]);
         default: ;
      endcase
   endfunction

   function automatic response_type predict_response(logic [POS_W-1:0] p,
                                                     logic [FILT_W-1:0] f);
      response_type r;
      logic signed [63:0] acc;
      logic signed [63:0] scaled;
      int tap;
      int xi;
      r.activation = '0;
      r.patch = p;
      r.filter = f;
      r.saturated = 1'b0;
      if (f < filters_live) begin
         acc = 64'(bias_mem[f]);
         for (int s = 0; s < splices; s++) begin
            if (s * taps_per_splice >= TAP_SLOTS) break;
            for (int d = 0; d < taps_per_splice; d++) begin
               tap = s * taps_per_splice + d;
               xi = p * patch_hop + s * splice_gap + d;
               if (tap < TAP_SLOTS && xi < FEAT_DEPTH)
                  acc += coef_mem[f][tap] * feat_mem[xi];
            end
         end
         scaled = acc >>> acc_shift;
         if (scaled > ACT_HI) begin
            r.activation = ACT_HI[31:0];
            r.saturated = 1'b1;
         end else if (scaled < ACT_LO) begin
            r.activation = ACT_LO[31:0];
            r.saturated = 1'b1;
         end else begin
            r.activation = scaled[31:0];
         end
      end
      return r;
   endfunction

   task automatic send_word(op_type op, logic [POS_W-1:0] pos, logic [FILT_W-1:0] f,
                            logic [SAMPLE_W-1:0] smp, logic [BIAS_W-1:0] bv);
      int gap;
      gap = req_gaps_on ? idle_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_position <= pos;
      req_filter_index <= f;
      req_sample <= smp;
      req_bias_value <= bv;
      do @(posedge clock); while (!req_ready);
      words_accepted++;
      case (op)
         OP_WEIGHT: if (pos < TAP_SLOTS) begin
            coef_mem[f][pos] = smp;
            coef_known[f][pos] = 1'b1;
            useful_words++;
         end
         OP_BIAS: begin
            bias_mem[f] = bv;
            bias_known[f] = 1'b1;
            useful_words++;
         end
         OP_FEATURE: if (pos < FEAT_DEPTH) begin
            feat_mem[pos] = smp;
            feat_known[pos] = 1'b1;
            useful_words++;
         end
         OP_COMPUTE: begin
            pending_responses.insert(pending_responses.size(), predict_response(pos, f));
            useful_words++;
         end
         default: ;
      endcase
   endtask

   // writes every store entry the compute word will read that is still unknown
   task automatic load_operands(logic [POS_W-1:0] p, logic [FILT_W-1:0] f);
      int tap;
      int xi;
      if (f < filters_live) begin
         if (!bias_known[f]) send_word(OP_BIAS, p, f, draw_sample(), draw_bias());
         for (int s = 0; s < splices; s++) begin
            if (s * taps_per_splice >= TAP_SLOTS) break;
            for (int d = 0; d < taps_per_splice; d++) begin
               tap = s * taps_per_splice + d;
               xi = p * patch_hop + s * splice_gap + d;
               if (tap < TAP_SLOTS && !coef_known[f][tap])
                  send_word(OP_WEIGHT, POS_W'(tap), f, draw_sample(), $urandom());
               if (tap < TAP_SLOTS && xi < FEAT_DEPTH && !feat_known[xi])
                  send_word(OP_FEATURE, POS_W'(xi), FILT_W'($urandom()), draw_sample(),
                            $urandom());
            end
         end
      end
   endtask

   task automatic run_patch(logic [POS_W-1:0] p, logic [FILT_W-1:0] f);
      load_operands(p, f);
      send_word(OP_COMPUTE, p, f, draw_sample(), $urandom());
   endtask

   task automatic drain_block(int settle);
      req_valid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      apply_csr(idx, data);
   endtask

   task automatic set_config(int unsigned pw, int unsigned step, int unsigned stride,
                             int unsigned sc, int unsigned fc, int unsigned sh);
      drain_block(CSR_SETTLE);
      write_reg(CSR_PATCH_WIDTH, CSR_DATA_W'(pw));
      write_reg(CSR_PATCH_STEP, CSR_DATA_W'(step));
      write_reg(CSR_SPLICE_STRIDE, CSR_DATA_W'(stride));
      write_reg(CSR_SPLICE_COUNT, CSR_DATA_W'(sc));
      write_reg(CSR_FILTER_COUNT, CSR_DATA_W'(fc));
      write_reg(CSR_OUT_SHIFT, CSR_DATA_W'(sh));
      csr_write <= 1'b0;
      settings_used++;
   endtask

   task automatic check_response();
      response_type want;
      if (pending_responses.size() == 0) begin
         $display("%0t: unexpected response: activation %0d patch %0d filter %0d",
                  $time, rsp_activation, rsp_out_patch, rsp_out_filter);
         mismatches++;
         return;
      end
      want = pending_responses.pop_front();
      responses_checked++;
      if (want.saturated && !want.activation[ACT_W-1]) sat_high++;
      if (want.saturated && want.activation[ACT_W-1]) sat_low++;
      if (rsp_activation !== want.activation) begin
         $display("%0t: activation expected %0d, got %0d", $time, want.activation,
                  rsp_activation);
         mismatches++;
      end
      if (rsp_out_patch !== want.patch) begin
         $display("%0t: out_patch expected %0d, got %0d", $time, want.patch, rsp_out_patch);
         mismatches++;
      end
      if (rsp_out_filter !== want.filter) begin
         $display("%0t: out_filter expected %0d, got %0d", $time, want.filter, rsp_out_filter);
         mismatches++;
      end
      if (rsp_saturated !== want.saturated) begin
         $display("%0t: saturated expected %0b, got %0b", $time, want.saturated, rsp_saturated);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_response();
      if (rsp_hold_request > 0) begin
         rsp_hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_stalls_on && $urandom_range(0, 3) == 0) rsp_stall_left = idle_gap();
      end
   end

   task automatic test_directed_extremes();
      set_config(1, 1, 1, 1, 2, 0);
      send_word(OP_WEIGHT, 0, 0, 16'h8000, '0);
      send_word(OP_WEIGHT, 0, 1, 16'h7FFF, '1);
      send_word(OP_WEIGHT, TAP_SLOTS - 1, FILTER_SLOTS - 1, 16'h8000, '0);
      send_word(OP_WEIGHT, 1023, 5, 16'h0001, '0);      // tap beyond store, dropped
      send_word(OP_BIAS, 0, 0, '0, 32'h7FFF_FFFF);
      send_word(OP_BIAS, 1023, 1, '1, 32'h8000_0000);
      send_word(OP_BIAS, 0, FILTER_SLOTS - 1, '0, '0);
      send_word(OP_FEATURE, 0, 0, 16'h8000, '0);
      send_word(OP_FEATURE, 1023, 63, 16'h8000, '1);
      send_word(OP_FEATURE, 1, 0, 16'h7FFF, '0);
      run_patch(0, 0);        // clips high
      run_patch(0, 1);        // clips low
      run_patch(1023, 1);
      run_patch(1, 0);
      run_patch(0, 63);       // filter not in use
      run_patch(1023, 63);
      set_config(1, 1024, 1, 1, 2, 31);
      run_patch(0, 0);
      run_patch(0, 1);        // floor of a negative value
      run_patch(1, 0);        // patch lies past the feature store
   endtask

   task automatic test_register_clamping();
      set_config(0, 0, 0, 0, 0, 11'h7E0);
      run_patch(5, 0);
      run_patch(6, 1);
      set_config(11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF, 11'h7FF);
      run_patch(0, 0);
      run_patch(1, 63);
      drain_block(CSR_SETTLE);
      write_reg(CSR_SPARE_LO, 11'h7FF);
      write_reg(CSR_SPARE_HI, 11'h001);
      csr_write <= 1'b0;
      run_patch(0, 0);
      set_config(200, 1, 3, 2, 64, 12);   // 400 taps, upper ones dropped
      run_patch(2, 0);
      run_patch(3, 21);
      set_config(1, 2, 4, 256, 64, 8);
      run_patch(1, 0);
      set_config(256, 1, 1, 1, 64, 0);
      run_patch(0, 63);
   endtask

   task automatic test_output_backpressure();
      set_config(4, 3, 2, 2, 64, 4);
      req_gaps_on = 1'b0;
      rsp_stalls_on = 1'b0;
      for (int k = 0; k < 8; k++) load_operands(POS_W'(k), FILT_W'(k));
      rsp_hold_request = HOLD_CYCLES;
      for (int k = 0; k < 8; k++)
         send_word(OP_COMPUTE, POS_W'(k), FILT_W'(k), draw_sample(), $urandom());
      drain_block(CSR_SETTLE);
   endtask

   task automatic random_word();
      int r;
      logic [POS_W-1:0] p;
      r = $urandom_range(0, 99);
      p = POS_W'($urandom_range(0, 1) ? $urandom_range(0, 1023)
                 : $urandom_range(0, 1023 / patch_hop));
      if (r < 45)
         run_patch(p, pick_filter());
      else if (r < 60)
         send_word(OP_FEATURE, POS_W'($urandom_range(0, 1023)), FILT_W'($urandom()),
                   draw_sample(), $urandom());
      else if (r < 80)
         send_word(OP_WEIGHT, POS_W'(($urandom_range(0, 4) == 0)
                   ? $urandom_range(TAP_SLOTS, 1023) : $urandom_range(0, TAP_SLOTS - 1)),
                   FILT_W'($urandom()), draw_sample(), $urandom());
      else if (r < 90)
         send_word(OP_BIAS, POS_W'($urandom()), FILT_W'($urandom()), draw_sample(),
                   draw_bias());
      else if (filters_live < FILTER_SLOTS)
         run_patch(p, FILT_W'($urandom_range(filters_live, FILTER_SLOTS - 1)));
      else
         run_patch(p, pick_filter());
   endtask

   // random phases fill up the word budget left after the directed tests
   task automatic test_random_traffic();
      int unsigned phase_start;
      int unsigned burst;
      while (words_accepted < TOTAL_WORDS) begin
         set_config(draw_setting(8, 256), draw_setting(4, 1024), draw_setting(4, 1024),
                    draw_setting(4, 256), draw_setting(64, 64), draw_setting(31, 31) - 1);
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         burst = $urandom_range(60, 120);
         phase_start = useful_words;
         while (useful_words - phase_start < burst && words_accepted < TOTAL_WORDS)
            random_word();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_register_clamping();
      test_output_backpressure();
      test_random_traffic();
      drain_block(END_SETTLE);
      $display("covered %0d words, %0d responses checked over %0d register settings",
               words_accepted, responses_checked, settings_used);
      $display("clipped high %0d, clipped low %0d, one %0d-cycle output stall",
               sat_high, sat_low, HOLD_CYCLES);
      if (mismatches == 0)
         $display("patch_convolution_forward_tb: PASS");
      else
         $display("patch_convolution_forward_tb: FAIL");
      $finish;
   end

endmodule
